// ===== hdl/bounded_sequential_list_assert.svh =====
// Assertion macros shared by the list checker.
// Needs nothing else; included by name where assertions are written.
`ifndef BOUNDED_SEQUENTIAL_LIST_ASSERT_SVH
`define BOUNDED_SEQUENTIAL_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define BSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("list check failed");

// Next-cycle implication, disabled while reset is low
`define BSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("list check failed");

`endif

// ===== hdl/bsl_pkg.sv =====
// Shared codes for the bounded sequential list: commands, status, cell ops.
// No dependencies.
package bsl_pkg;

  // Command codes of the input beat
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_BACK   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_FIND       = 3'd4;
  localparam logic [2:0] CMD_INSERT     = 3'd5;
  localparam logic [2:0] CMD_ERASE      = 3'd6;

  // Status codes of the result beat
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Beat widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_e;

endpackage

// ===== hdl/bsl_cell.sv =====
// One storage cell of the list chain; trades its word with its neighbors.
// Depends on bsl_pkg for the cell operation codes.
module bsl_cell #(
  parameter int INDEX      = 0,
  parameter int IW         = 6,
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk_i,
  input  bsl_pkg::cell_op_e     op_i,
  input  logic [IW-1:0]         idx_i,       // insert/remove slot, or last slot for rotate
  input  logic [WORD_WIDTH-1:0] new_word_i,
  input  logic [WORD_WIDTH-1:0] left_i,      // word of slot INDEX-1
  input  logic [WORD_WIDTH-1:0] right_i,     // word of slot INDEX+1
  input  logic [WORD_WIDTH-1:0] head_i,      // word of slot 0
  output logic [WORD_WIDTH-1:0] word_o
);
  import bsl_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic [WORD_WIDTH-1:0] word_q, word_d;

  // Pick the next word from the op and this cell's place relative to idx
  always_comb begin
    word_d = word_q;
    unique case (op_i)
      CELL_INSERT: begin
        if (MY_IDX > idx_i) begin
          word_d = left_i;
        end else if (MY_IDX == idx_i) begin
          word_d = new_word_i;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= idx_i) begin
          word_d = right_i;
        end
      end
      CELL_ROTATE: begin
        if (MY_IDX < idx_i) begin
          word_d = right_i;
        end else if (MY_IDX == idx_i) begin
          word_d = head_i;
        end
      end
      default: begin
        word_d = word_q;
      end
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== hdl/bounded_sequential_list.sv =====
// Bounded ordered list of up to DEPTH words held in a chain of cells. Push,
// pop front, insert and erase shift the cells at once, and pop back only
// lowers the count: the beat is taken, the chain and count update on that
// edge, and the result beat is registered. Find on an empty list answers the
// same way. Find on a non-empty list rotates the stored words through the
// chain one slot per cycle and compares the word at the head. It occupies
// the block for an accept step, one rotation step per stored word and a
// result step, and holds longer if the result register is still full when
// the scan ends. After the full turn the list is back in its original order.
// A new command is taken in the idle state while a result waits, as long as
// the output register is free or is being emptied in the same cycle. No
// clearing pass is needed after reset.
// Depends on bsl_pkg and bsl_cell.
module bounded_sequential_list #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] command, [34:3] value, [41:35] position, [47:42] zero
  input  logic [bsl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [2] found, [9:3] match_position, [16:10] element_total,
  // [23:17] zero
  output logic [bsl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import bsl_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int VW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Input beat fields
  logic [2:0]            in_cmd;
  logic [31:0]           in_value;
  logic [6:0]            in_pos;
  logic [WORD_WIDTH-1:0] in_word;

  assign in_cmd   = s_axis_tdata[2:0];
  assign in_value = s_axis_tdata[34:3];
  assign in_pos   = s_axis_tdata[41:35];
  assign in_word  = WORD_WIDTH'(in_value[VW-1:0]);

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic [IW-1:0]         step_q, step_d;
  logic                  found_q, found_d;
  logic [CW-1:0]         match_q, match_d;
  logic [WORD_WIDTH-1:0] key_q, key_d;

  logic [1:0]            out_status_q;
  logic                  out_found_q;
  logic [CW-1:0]         out_match_q;
  logic [CW-1:0]         out_total_q;

  logic                  accept, out_free, load;
  logic [1:0]            res_status;
  logic [1:0]            cmd_status;
  logic                  res_found;
  logic [CW-1:0]         res_match, res_total;
  cell_op_e              cell_op;
  logic [IW-1:0]         cell_idx;
  logic [PW-1:0]         pos_x, cnt_x;
  logic                  is_full, is_empty;

  logic [WORD_WIDTH-1:0] cell_word [DEPTH];
  logic [WORD_WIDTH-1:0] left_w    [DEPTH];
  logic [WORD_WIDTH-1:0] right_w   [DEPTH];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pos_x         = PW'(in_pos);
  assign cnt_x         = PW'(count_q);
  assign is_full       = (count_q == FULL_CNT);
  assign is_empty      = (count_q == '0);

  // Command decode: chain op, slot and new count for the accepted beat, or the rotate op during a scan
  always_comb begin
    cell_op    = CELL_HOLD;
    cell_idx   = '0;
    count_d    = count_q;
    cmd_status = ST_OK;
    if (state_q == S_SCAN) begin
      cell_op  = CELL_ROTATE;
      cell_idx = IW'(count_q - CW'(1));
    end else if (accept) begin
      unique case (in_cmd)
        CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
          if (is_full) begin
            cmd_status = ST_FULL;
          end else begin
            cell_op = CELL_INSERT;
            count_d = count_q + CW'(1);
            if (in_cmd == CMD_PUSH_BACK) begin
              cell_idx = IW'(count_q);
            end else if (in_cmd == CMD_PUSH_FRONT || pos_x <= PW'(1)) begin
              cell_idx = '0;
            end else if (pos_x >= cnt_x) begin
              cell_idx = IW'(count_q);
            end else begin
              cell_idx = IW'(pos_x - PW'(1));
            end
          end
        end
        CMD_POP_BACK: begin
          if (is_empty) begin
            cmd_status = ST_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty) begin
            cmd_status = ST_EMPTY;
          end else begin
            cell_op = CELL_REMOVE;
            count_d = count_q - CW'(1);
          end
        end
        CMD_ERASE: begin
          if (is_empty) begin
            cmd_status = ST_EMPTY;
          end else if (pos_x == '0 || pos_x > cnt_x) begin
            cmd_status = ST_RANGE;
          end else begin
            cell_op  = CELL_REMOVE;
            cell_idx = IW'(pos_x - PW'(1));
            count_d  = count_q - CW'(1);
          end
        end
        default: begin
          cmd_status = ST_OK;
        end
      endcase
    end
  end

  // Sequencer: immediate results, find scan and result load
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    found_d    = found_q;
    match_d    = match_q;
    key_d      = key_q;
    load       = 1'b0;
    res_status = ST_OK;
    res_found  = 1'b0;
    res_match  = '0;
    res_total  = count_d;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_FIND && !is_empty) begin
            state_d = S_SCAN;
            key_d   = in_word;
            step_d  = '0;
            found_d = 1'b0;
            match_d = '0;
          end else begin
            load       = 1'b1;
            res_status = cmd_status;
          end
        end
      end
      S_SCAN: begin
        if (!found_q && cell_word[0] == key_q) begin
          found_d = 1'b1;
          match_d = CW'(step_q) + CW'(1);
        end
        step_d = IW'(step_q + IW'(1));
        if (step_q == IW'(count_q - CW'(1))) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load      = 1'b1;
          res_found = found_q;
          res_match = match_q;
          res_total = count_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = load || (out_valid_q && !m_axis_tready);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      found_q     <= found_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    match_q <= match_d;
    if (load) begin
      out_status_q <= res_status;
      out_found_q  <= res_found;
      out_match_q  <= res_match;
      out_total_q  <= res_total;
    end
  end

  // Neighbor wiring; the end cells see their own word past the edge
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_w[k] = cell_word[k];
    end else begin : g_mid_l
      assign left_w[k] = cell_word[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w[k] = cell_word[k];
    end else begin : g_mid_r
      assign right_w[k] = cell_word[k+1];
    end

    bsl_cell #(
      .INDEX      (k),
      .IW         (IW),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (cell_op),
      .idx_i      (cell_idx),
      .new_word_i (in_word),
      .left_i     (left_w[k]),
      .right_i    (right_w[k]),
      .head_i     (cell_word[0]),
      .word_o     (cell_word[k])
    );
  end

  // Result beat
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0,
                          7'(PW'(out_total_q)),
                          7'(PW'(out_match_q)),
                          out_found_q,
                          out_status_q};

endmodule

// ===== hdl/bsl_checker.sv =====
// Port-level checks on the bounded sequential list result stream.
// Depends on bsl_pkg and bounded_sequential_list_assert.svh; bound to the top.
`include "bounded_sequential_list_assert.svh"

module bsl_checker #(
  parameter int DEPTH = 64
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bsl_pkg::*;

  logic [1:0] st;
  logic       fnd;
  logic [6:0] mpos;
  logic [6:0] tot;
  logic       out_stall;

  assign st        = m_axis_tdata[1:0];
  assign fnd       = m_axis_tdata[2];
  assign mpos      = m_axis_tdata[9:3];
  assign tot       = m_axis_tdata[16:10];
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // A match always carries a real position and an ok status
  `BSL_ASSERT_IMP(a_found_pos, clk_i, rst_ni, m_axis_tvalid && fnd, mpos != 7'd0 && st == ST_OK)
  // No match, no position
  `BSL_ASSERT_IMP(a_nofind_pos, clk_i, rst_ni, m_axis_tvalid && !fnd, mpos == 7'd0)
  // A rejected add reports a full list
  `BSL_ASSERT_IMP(a_full_total, clk_i, rst_ni, m_axis_tvalid && st == ST_FULL, tot == 7'(DEPTH))
  // A stalled result beat holds
  `BSL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind bounded_sequential_list bsl_checker #(
  .DEPTH (DEPTH)
) u_bsl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
